// File: rtl/bmh_pkg.sv
package bmh_pkg;

  // Default number of entries the heap can hold
  localparam int unsigned CAPACITY_DEF = 127;

  localparam int unsigned PRIO_W      = 16;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned ENTRY_W     = PRIO_W + DATA_W;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ENTRY_CNT_W = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DEL_ROOT,
    ST_DEL_LAST,
    ST_DEL_STEP,
    ST_DEL_LEFT,
    ST_DEL_RIGHT,
    ST_DEL_CMP,
    ST_DONE
  } state_e;

  typedef logic [ENTRY_W-1:0] entry_t;

  // Priority sits in the upper half of an entry, data in the lower half
  function automatic logic [PRIO_W-1:0] prio_of(input entry_t e);
    return e[ENTRY_W-1:DATA_W];
  endfunction

  function automatic logic [DATA_W-1:0] data_of(input entry_t e);
    return e[DATA_W-1:0];
  endfunction

endpackage

// File: rtl/bmh_if.sv
interface bmh_req_if import bmh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [PRIO_W-1:0] item_priority;
  logic [DATA_W-1:0] item_data;

  modport source (output valid, command, item_priority, item_data, input ready);
  modport sink   (input valid, command, item_priority, item_data, output ready);
endinterface

interface bmh_rsp_if import bmh_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [DATA_W-1:0]      removed_data;
  logic [STATUS_W-1:0]    status;
  logic [ENTRY_CNT_W-1:0] entry_count;
  logic                   is_empty;

  modport source (output valid, removed_data, status, entry_count, is_empty, input ready);
  modport sink   (input valid, removed_data, status, entry_count, is_empty, output ready);
endinterface

// File: rtl/bmh_ram.sv
module bmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/binary_min_heap_priority_queue.sv
// Insert: the new entry climbs from the first free slot toward the root, one level per
// parent read and compare. Delete: the last entry sinks from the root, L = levels sunk
// (<= floor(log2(CAPACITY))); a level with only a left child skips the right-child read.
// A failed operation (delete when empty, insert when full) goes straight to its result.
// One shared comparator; one operation in flight, the next transaction taken in the
// cycle after its result loads, later if an earlier result still waits.
// Reset empties the heap (count to zero); the RAM contents are not cleared.
module binary_min_heap_priority_queue import bmh_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmh_req_if.sink   in_i,
  bmh_rsp_if.source out_o
);

  // Slot 0 is unused, slots 1..CAPACITY hold the heap
  localparam int unsigned DEPTH = CAPACITY + 1;
  localparam int unsigned CNT_W = $clog2(DEPTH);
  // Child indices reach 2*CAPACITY+1, so they need one bit more
  localparam int unsigned IDX_W = CNT_W + 1;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  child_idx_q, child_idx_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [DATA_W-1:0] data_q, data_d;
  entry_t            last_q, last_d;
  entry_t            child_q, child_d;
  logic [DATA_W-1:0] removed_q, removed_d;
  status_e           status_q, status_d;

  // Result register
  logic                   out_valid_q;
  logic [DATA_W-1:0]      out_removed_q;
  status_e                out_status_q;
  logic [ENTRY_CNT_W-1:0] out_count_q;
  logic                   out_empty_q;
  logic                   out_load;

  // Heap RAM port
  logic             ram_we;
  logic [CNT_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [CNT_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  // Shared comparator
  logic [PRIO_W-1:0] cmp_a;
  logic [PRIO_W-1:0] cmp_b;
  logic              cmp_ge;

  logic             in_fire;
  logic             heap_full;
  logic             heap_none;
  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] right_idx;
  logic [IDX_W-1:0] cnt_ext;
  logic             pos_is_root;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign heap_full   = (cnt_q == CNT_W'(CAPACITY));
  assign heap_none   = (cnt_q == '0);
  assign left_idx    = {pos_q, 1'b0};
  assign right_idx   = {pos_q, 1'b1};
  assign cnt_ext     = {1'b0, cnt_q};
  assign pos_is_root = (pos_q == CNT_W'(1));

  bmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One comparator serves every step: a >= b
  always_comb begin
    unique case (state_q)
      ST_INS_CMP: begin
        // parent against the new entry
        cmp_a = prio_of(ram_rdata);
        cmp_b = prio_q;
      end
      ST_DEL_RIGHT: begin
        // right child against left child; left wins ties
        cmp_a = prio_of(ram_rdata);
        cmp_b = prio_of(child_q);
      end
      default: begin
        // sinking entry against the chosen child
        cmp_a = prio_of(last_q);
        cmp_b = prio_of(child_q);
      end
    endcase
  end

  assign cmp_ge = (cmp_a >= cmp_b);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_e'(in_i.command) == CMD_INSERT) begin
            state_d = heap_full ? ST_DONE : ST_INS_RD;
          end else begin
            state_d = heap_none ? ST_DONE : ST_DEL_ROOT;
          end
        end
      end
      ST_INS_RD:    state_d = pos_is_root ? ST_DONE : ST_INS_CMP;
      ST_INS_CMP:   state_d = cmp_ge ? ST_INS_RD : ST_DONE;
      ST_DEL_ROOT:  state_d = ST_DEL_LAST;
      ST_DEL_LAST:  state_d = ST_DEL_STEP;
      ST_DEL_STEP:  state_d = (left_idx > cnt_ext) ? ST_DONE : ST_DEL_LEFT;
      ST_DEL_LEFT:  state_d = (left_idx == cnt_ext) ? ST_DEL_CMP : ST_DEL_RIGHT;
      ST_DEL_RIGHT: state_d = ST_DEL_CMP;
      ST_DEL_CMP:   state_d = cmp_ge ? ST_DEL_STEP : ST_DONE;
      ST_DONE:      state_d = (!out_valid_q || out_o.ready) ? ST_IDLE : ST_DONE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    child_idx_d = child_idx_q;
    prio_d      = prio_q;
    data_d      = data_q;
    last_d      = last_q;
    child_d     = child_q;
    removed_d   = removed_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = last_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    out_load    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          prio_d    = in_i.item_priority;
          data_d    = in_i.item_data;
          removed_d = '0;
          status_d  = STATUS_OK;
          if (cmd_e'(in_i.command) == CMD_INSERT) begin
            if (heap_full) begin
              status_d = STATUS_FULL;
            end else begin
              // new entry starts in the first free slot
              pos_d = CNT_W'(cnt_q + CNT_W'(1));
            end
          end else begin
            if (heap_none) begin
              status_d = STATUS_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = CNT_W'(1);
            end
          end
        end
      end

      ST_INS_RD: begin
        if (pos_is_root) begin
          ram_we    = 1'b1;
          ram_wdata = {prio_q, data_q};
          cnt_d     = CNT_W'(cnt_q + CNT_W'(1));
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pos_q >> 1;
        end
      end

      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (cmp_ge) begin
          // pull the parent down and climb
          ram_wdata = ram_rdata;
          pos_d     = pos_q >> 1;
        end else begin
          ram_wdata = {prio_q, data_q};
          cnt_d     = CNT_W'(cnt_q + CNT_W'(1));
        end
      end

      ST_DEL_ROOT: begin
        removed_d = data_of(ram_rdata);
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
      end

      ST_DEL_LAST: begin
        last_d = ram_rdata;
        pos_d  = CNT_W'(1);
      end

      ST_DEL_STEP: begin
        if (left_idx > cnt_ext) begin
          ram_we = 1'b1;
          cnt_d  = CNT_W'(cnt_q - CNT_W'(1));
        end else begin
          ram_re    = 1'b1;
          ram_raddr = left_idx[CNT_W-1:0];
        end
      end

      ST_DEL_LEFT: begin
        child_d     = ram_rdata;
        child_idx_d = left_idx[CNT_W-1:0];
        if (left_idx != cnt_ext) begin
          ram_re    = 1'b1;
          ram_raddr = right_idx[CNT_W-1:0];
        end
      end

      ST_DEL_RIGHT: begin
        // right child only when the left one is strictly greater
        if (!cmp_ge) begin
          child_d     = ram_rdata;
          child_idx_d = right_idx[CNT_W-1:0];
        end
      end

      ST_DEL_CMP: begin
        ram_we = 1'b1;
        if (cmp_ge) begin
          // lift the child and descend
          ram_wdata = child_q;
          pos_d     = child_idx_q;
        end else begin
          cnt_d = CNT_W'(cnt_q - CNT_W'(1));
        end
      end

      ST_DONE: begin
        out_load = !out_valid_q || out_o.ready;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    child_idx_q <= child_idx_d;
    prio_q      <= prio_d;
    data_q      <= data_d;
    last_q      <= last_d;
    child_q     <= child_d;
    removed_q   <= removed_d;
    status_q    <= status_d;
    if (out_load) begin
      out_removed_q <= removed_q;
      out_status_q  <= status_q;
      out_count_q   <= ENTRY_CNT_W'(cnt_q);
      out_empty_q   <= heap_none;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.removed_data = out_removed_q;
  assign out_o.status       = out_status_q;
  assign out_o.entry_count  = out_count_q;
  assign out_o.is_empty     = out_empty_q;

  // Hold the count within capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= IDX_W'(CAPACITY))
    else $error("entry count above capacity");

  // Writes land only in slots 1..count+1
  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr != '0 && {1'b0, ram_waddr} <= IDX_W'(cnt_ext + IDX_W'(1))))
    else $error("heap write outside occupied range");

  // Count moves by at most one per operation
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)) || CNT_W'(cnt_q + CNT_W'(1)) == $past(cnt_q)))
    else $error("entry count jumped");

  // An accepted transaction always occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("transaction dropped");

  // A delete that found entries keeps the count unchanged while it reads the root
  a_del_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_e'(in_i.command) == CMD_DELETE && !heap_none) |=>
      (cnt_q == $past(cnt_q)))
    else $error("count changed before delete finished");

endmodule
